// ===== design/ladder_button_mode_fsm_unit_assert.svh =====
// Assertion macros shared by the ladder keypad decoder modules.
`ifndef LADDER_BUTTON_MODE_FSM_UNIT_ASSERT_SVH
`define LADDER_BUTTON_MODE_FSM_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check prop on every clock edge outside reset.
`define LBM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check prop on every clock edge, reset included.
`define LBM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LBM_ASSERT(name, clk, rstn, prop, msg)

`define LBM_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== design/lbm_pkg.sv =====
`timescale 1ns / 1ps

package lbm_pkg;

    localparam int SAMPLE_W       = 10;
    localparam int LEVEL_W        = 10;
    localparam int MODE_W         = 4;
    localparam int BUTTON_W       = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int WINDOW_DEFAULT = 100;

    localparam logic [LEVEL_W-1:0] RECORD_LEVEL_RST = 10'd100;
    localparam logic [LEVEL_W-1:0] PLAY_LEVEL_RST   = 10'd300;
    localparam logic [LEVEL_W-1:0] DOWN_LEVEL_RST   = 10'd500;
    localparam logic [LEVEL_W-1:0] UP_LEVEL_RST     = 10'd700;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE       = 4'd0,
        MODE_REC_START  = 4'd1,
        MODE_RECORDING  = 4'd2,
        MODE_REC_END    = 4'd3,
        MODE_PLAY_START = 4'd4,
        MODE_PLAYING    = 4'd5,
        MODE_PLAY_END   = 4'd6,
        MODE_FILE_UP    = 4'd7,
        MODE_FILE_DOWN  = 4'd8
    } mode_t;

    typedef enum logic [BUTTON_W-1:0] {
        BTN_NONE   = 3'd0,
        BTN_RECORD = 3'd1,
        BTN_PLAY   = 3'd2,
        BTN_DOWN   = 3'd3,
        BTN_UP     = 3'd4
    } button_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECORD_LEVEL = 2'd0,
        REG_PLAY_LEVEL   = 2'd1,
        REG_DOWN_LEVEL   = 2'd2,
        REG_UP_LEVEL     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] record_level;
        logic [LEVEL_W-1:0] play_level;
        logic [LEVEL_W-1:0] down_level;
        logic [LEVEL_W-1:0] up_level;
    } levels_t;

endpackage

// ===== design/lbm_classify.sv =====
`timescale 1ns / 1ps

module lbm_classify import lbm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic [SAMPLE_W-1:0] sample,
    input  levels_t             levels,
    output button_t             button
);

    localparam int SUM_W = $clog2((2**LEVEL_W) + WINDOW);

    function automatic logic in_window(input logic [SAMPLE_W-1:0] s,
                                       input logic [LEVEL_W-1:0]  level);
        logic [SUM_W-1:0] s_ext;
        logic [SUM_W-1:0] lo;
        logic [SUM_W-1:0] hi;
        s_ext = SUM_W'(s);
        lo    = SUM_W'(level);
        hi    = lo + SUM_W'(WINDOW);
        return (lo <= s_ext) && (s_ext < hi);
    endfunction

    always_comb begin
        if (in_window(sample, levels.record_level)) begin
            button = BTN_RECORD;
        end else if (in_window(sample, levels.play_level)) begin
            button = BTN_PLAY;
        end else if (in_window(sample, levels.down_level)) begin
            button = BTN_DOWN;
        end else if (in_window(sample, levels.up_level)) begin
            button = BTN_UP;
        end else begin
            button = BTN_NONE;
        end
    end

endmodule

// ===== design/lbm_mode_fsm.sv =====
`timescale 1ns / 1ps
`include "ladder_button_mode_fsm_unit_assert.svh"

module lbm_mode_fsm import lbm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  button_t button,
    output mode_t   mode_next
);

    mode_t   mode_reg;
    button_t last_button_reg;
    logic    from_none;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            last_button_reg <= BTN_NONE;
        end else if (advance) begin
            mode_reg        <= mode_next;
            last_button_reg <= button;
        end
    end

    assign from_none = (last_button_reg == BTN_NONE);

    always_comb begin
        mode_next = MODE_IDLE;
        case (mode_reg)
            MODE_IDLE: begin
                if (from_none) begin
                    case (button)
                        BTN_RECORD: mode_next = MODE_REC_START;
                        BTN_PLAY:   mode_next = MODE_PLAY_START;
                        BTN_UP:     mode_next = MODE_FILE_UP;
                        BTN_DOWN:   mode_next = MODE_FILE_DOWN;
                        default:    mode_next = MODE_IDLE;
                    endcase
                end
            end
            MODE_REC_START: mode_next = MODE_RECORDING;
            MODE_RECORDING: begin
                mode_next = (from_none && button == BTN_RECORD) ? MODE_REC_END
                                                                : MODE_RECORDING;
            end
            MODE_PLAY_START: mode_next = MODE_PLAYING;
            MODE_PLAYING: begin
                mode_next = (from_none && button == BTN_PLAY) ? MODE_PLAY_END
                                                              : MODE_PLAYING;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    `LBM_ASSERT(a_state_hold, aclk, aresetn,
        !advance |=> $stable(mode_reg) && $stable(last_button_reg),
        "mode state changed without a request")
    `LBM_ASSERT(a_rec_start_once, aclk, aresetn,
        advance && mode_reg == MODE_REC_START |=> mode_reg == MODE_RECORDING,
        "rec start did not move to recording")
    `LBM_ASSERT(a_press_needs_none, aclk, aresetn,
        advance && mode_reg == MODE_IDLE && !from_none |=> mode_reg == MODE_IDLE,
        "held button left idle")

endmodule

// ===== design/ladder_button_mode_fsm_unit.sv =====
`timescale 1ns / 1ps
`include "ladder_button_mode_fsm_unit_assert.svh"

// Resistor ladder keypad decoder with a record/play mode machine.
// Input channel s_*: one ten-bit ladder sample per request (s_valid/s_ready).
// Result channel m_*: the new mode and this sample's button class per request.
// Configuration: cfg_wr_en writes cfg_wr_data into the window level selected
// by cfg_index (record, play, file down, file up); write only while idle.
// Each sample is classified against four windows, WINDOW counts wide, in
// priority order, and the mode machine steps once per request.
// Flow: a request accepted into the input register moves on to the result
// register when that register is empty or m_ready is high, and shows on m_*.
// Throughput: one request per cycle while m_ready stays high, set by the
// combinational classify-and-step logic between the input and result registers.
// Reset: mode goes to idle, the last button to none, levels to 100, 300,
// 500 and 700, and both pipeline stages empty.
// Receiver stall: the result register holds; one more request sits in the
// input register, then s_ready drops until m_ready returns.
module ladder_button_mode_fsm_unit import lbm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MODE_W-1:0]    m_mode,
    output logic [BUTTON_W-1:0]  m_button,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_wr_data
);

    levels_t             levels_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    mode_t               mode_out_reg;
    button_t             button_out_reg;
    logic                advance;
    logic                accept;
    button_t             button;
    mode_t               mode_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg.record_level <= RECORD_LEVEL_RST;
            levels_reg.play_level   <= PLAY_LEVEL_RST;
            levels_reg.down_level   <= DOWN_LEVEL_RST;
            levels_reg.up_level     <= UP_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_RECORD_LEVEL: levels_reg.record_level <= cfg_wr_data;
                REG_PLAY_LEVEL:   levels_reg.play_level   <= cfg_wr_data;
                REG_DOWN_LEVEL:   levels_reg.down_level   <= cfg_wr_data;
                REG_UP_LEVEL:     levels_reg.up_level     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
    end

    lbm_classify #(
        .WINDOW (WINDOW)
    ) u_classify (
        .sample (sample_reg),
        .levels (levels_reg),
        .button (button)
    );

    lbm_mode_fsm u_mode_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .button    (button),
        .mode_next (mode_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mode_out_reg   <= mode_next;
            button_out_reg <= button;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_mode   = MODE_W'(mode_out_reg);
    assign m_button = BUTTON_W'(button_out_reg);

    `LBM_ASSERT(a_advance_fills, aclk, aresetn,
        advance |=> m_valid,
        "result register empty after a request moved forward")
    `LBM_ASSERT(a_stall_holds_input, aclk, aresetn,
        in_valid_reg && !advance |=> in_valid_reg && $stable(sample_reg),
        "stalled request lost from the input register")
    `LBM_ASSERT_ALWAYS(a_ready_when_empty, aclk,
        !in_valid_reg |-> s_ready,
        "input register empty but not ready")

endmodule

// ===== dv/ladder_button_mode_fsm_unit_test.sv =====
`timescale 1ns / 1ps

module ladder_button_mode_fsm_unit_test;
    import lbm_pkg::*;

    localparam int WINDOW           = WINDOW_DEFAULT;
    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;

    typedef struct packed {
        mode_t   mode;
        button_t button;
    } key_event_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample;
    logic                 m_valid;
    logic                 m_ready;
    logic [MODE_W-1:0]    m_mode;
    logic [BUTTON_W-1:0]  m_button;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_wr_data;

    levels_t    ladder_levels;
    mode_t      mode_now;
    button_t    last_class;
    key_event_t expected_keys [$];
    int         fail_count = 0;
    int         idle_cycles = 0;
    bit         traffic_gaps = 1'b0;

    ladder_button_mode_fsm_unit #(
        .WINDOW(WINDOW)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample(s_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_mode(m_mode),
        .m_button(m_button),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit in_window(logic [SAMPLE_W-1:0] s, logic [LEVEL_W-1:0] lvl);
        return int'(s) >= int'(lvl) && int'(s) < int'(lvl) + WINDOW;
    endfunction

    function automatic button_t classify_sample(logic [SAMPLE_W-1:0] s);
        if (in_window(s, ladder_levels.record_level)) return BTN_RECORD;
        if (in_window(s, ladder_levels.play_level))   return BTN_PLAY;
        if (in_window(s, ladder_levels.down_level))   return BTN_DOWN;
        if (in_window(s, ladder_levels.up_level))     return BTN_UP;
        return BTN_NONE;
    endfunction

    function automatic mode_t advance_mode(button_t key);
        bit from_none;
        from_none = (last_class == BTN_NONE);
        case (mode_now)
            MODE_IDLE: begin
                if (!from_none) return MODE_IDLE;
                case (key)
                    BTN_RECORD: return MODE_REC_START;
                    BTN_PLAY:   return MODE_PLAY_START;
                    BTN_UP:     return MODE_FILE_UP;
                    BTN_DOWN:   return MODE_FILE_DOWN;
                    default:    return MODE_IDLE;
                endcase
            end
            MODE_REC_START:  return MODE_RECORDING;
            MODE_RECORDING:  return (from_none && key == BTN_RECORD) ? MODE_REC_END : MODE_RECORDING;
            MODE_PLAY_START: return MODE_PLAYING;
            MODE_PLAYING:    return (from_none && key == BTN_PLAY) ? MODE_PLAY_END : MODE_PLAYING;
            default:         return MODE_IDLE;
        endcase
    endfunction

    function automatic void step_keypad(logic [SAMPLE_W-1:0] s);
        button_t key;
        key = classify_sample(s);
        mode_now = advance_mode(key);
        last_class = key;
        expected_keys.push_back('{mode: mode_now, button: key});
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!traffic_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic button_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return BTN_RECORD;
        if (r < 70) return BTN_PLAY;
        if (r < 85) return BTN_DOWN;
        return BTN_UP;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_for(button_t key);
        logic [SAMPLE_W-1:0] s;
        int lvl;
        int hi;
        case (key)
            BTN_RECORD: lvl = int'(ladder_levels.record_level);
            BTN_PLAY:   lvl = int'(ladder_levels.play_level);
            BTN_DOWN:   lvl = int'(ladder_levels.down_level);
            BTN_UP:     lvl = int'(ladder_levels.up_level);
            default: begin
                s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                for (int i = 0; i < 16 && classify_sample(s) != BTN_NONE; i++)
                    s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                return s;
            end
        endcase
        hi = lvl + WINDOW - 1;
        if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
        return SAMPLE_W'($urandom_range(lvl, hi));
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        step_keypad(v);
    endtask

    // drop valid and drain every pending result before touching the levels
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_keys.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_levels(input logic [LEVEL_W-1:0] rec, play, down, up);
        cfg_idx_t order [4] = '{REG_RECORD_LEVEL, REG_PLAY_LEVEL, REG_DOWN_LEVEL, REG_UP_LEVEL};
        logic [LEVEL_W-1:0] vals [4];
        vals = '{rec, play, down, up};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= order[i];
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        ladder_levels = '{rec, play, down, up};
    endtask

    task automatic test_default_windows();
        int seq [18] = '{0, 100, 199, 350, 0, 150, 0, 399, 0, 300,
                         500, 0, 799, 750, 0, 500, 1023, 699};
        traffic_gaps = 1'b0;
        foreach (seq[i]) send_sample(SAMPLE_W'(seq[i]));
    endtask

    task automatic test_window_priority();
        int seq [6] = '{0, 99, 149, 1023, 980, 1022};
        settle();
        set_levels(10'd0, 10'd50, 10'd1023, 10'd960);
        foreach (seq[i]) send_sample(SAMPLE_W'(seq[i]));
    endtask

    task automatic run_random_phase(input int n_items);
        int sent;
        button_t key;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 78) begin
                key = pick_key();
                repeat ($urandom_range(1, 2)) begin
                    send_sample(sample_for(BTN_NONE));
                    sent++;
                end
                repeat ($urandom_range(1, 4)) begin
                    send_sample(sample_for(key));
                    sent++;
                end
            end else begin
                send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 7; phase++) begin
            settle();
            traffic_gaps = (phase != 0);
            case (phase)
                0: set_levels(RECORD_LEVEL_RST, PLAY_LEVEL_RST, DOWN_LEVEL_RST, UP_LEVEL_RST);
                1: set_levels(LEVEL_W'($urandom_range(0, 155)),
                              LEVEL_W'($urandom_range(256, 411)),
                              LEVEL_W'($urandom_range(512, 667)),
                              LEVEL_W'($urandom_range(768, 923)));
                3: set_levels('0, '0, '0, '0);
                4: set_levels('1, '1, '1, '1);
                5: set_levels(10'd1023, 10'd0, 10'd512, 10'd923);
                default: set_levels(LEVEL_W'($urandom_range(0, SAMPLE_MAX)),
                                    LEVEL_W'($urandom_range(0, SAMPLE_MAX)),
                                    LEVEL_W'($urandom_range(0, SAMPLE_MAX)),
                                    LEVEL_W'($urandom_range(0, SAMPLE_MAX)));
            endcase
            run_random_phase(RANDOM_PER_PHASE);
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 99) < 80 ? $urandom_range(1, 6) : $urandom_range(8, 30))
                @(posedge aclk);
            if (traffic_gaps) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 99) < 92 ? $urandom_range(1, 6) : $urandom_range(10, 25))
                    @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        key_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_keys.size() == 0) begin
                $error("unexpected result: mode %0d, button %0d", m_mode, m_button);
                fail_count++;
            end else begin
                want = expected_keys.pop_front();
                if (m_mode !== want.mode) begin
                    $error("mode: expected %0d, actual %0d", want.mode, m_mode);
                    fail_count++;
                end
                if (m_button !== want.button) begin
                    $error("button: expected %0d, actual %0d", want.button, m_button);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_sample    <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_RECORD_LEVEL;
        cfg_wr_data <= '0;
        ladder_levels = '{RECORD_LEVEL_RST, PLAY_LEVEL_RST, DOWN_LEVEL_RST, UP_LEVEL_RST};
        mode_now      = MODE_IDLE;
        last_class    = BTN_NONE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_windows();
        test_window_priority();
        test_random_phases();

        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_keys.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
